### hdl/dtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_pkg
// Widths, scaling constants and the divider cell type of the two-way ranging
// distance pipeline.
// ----------------------------------------------------------------------------
package dtw_pkg;

  localparam int TS_W    = 40;              // timestamp bits used
  localparam int IN_W    = 40;              // timestamp port width
  localparam int LO_W    = (TS_W + 1) / 2;  // low half of a multiplier operand
  localparam int HI_W    = TS_W - LO_W;
  localparam int PROD_W  = 2 * TS_W;
  localparam int SUM_W   = TS_W + 2;        // sum of four intervals
  localparam int EXT_W   = 48;              // quotient as seen by the scaler

  localparam logic [15:0] SCALE_NUM = 16'd46903;
  localparam longint      SCALE_DEN = 100000;

  // smallest quotient whose scaled value passes 16 bits
  localparam logic [EXT_W-1:0] SAT_TOF =
    EXT_W'((64'd65536 * 64'(SCALE_DEN) + 64'(SCALE_NUM) - 64'd1) / 64'(SCALE_NUM));
  localparam int CAP_W = 18;                // quotient bits below SAT_TOF

  // divide by 100000 as a shift by 5 and a reciprocal multiply by 1/3125
  localparam int     DEN_SHIFT   = 5;
  localparam longint DEN_ODD     = SCALE_DEN >> DEN_SHIFT;
  localparam int     SP_W        = CAP_W + 16;          // scaled product
  localparam int     X_W         = 28;                  // scaled product >> 5
  localparam int     RECIP_SHIFT = 40;
  localparam int     RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));
  localparam int     RP_W        = X_W + RECIP_W;

  typedef struct packed {
    logic              vld;
    logic [SUM_W-1:0]  rem;
    logic [TS_W-1:0]   dvd;
    logic [TS_W-1:0]   quo;
    logic [SUM_W-1:0]  den;
    logic              neg;
    logic              zero;
  } cell_t;

endpackage

### hdl/dtw_wide_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_wide_mul
// Two-stage full-width unsigned product of two intervals: four half-width
// partial products, then their aligned sum.
// ----------------------------------------------------------------------------
module dtw_wide_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [dtw_pkg::TS_W-1:0]   a_i,
  input  logic [dtw_pkg::TS_W-1:0]   b_i,
  output logic [dtw_pkg::PROD_W-1:0] p_o
);

  logic [2*dtw_pkg::LO_W-1:0]            pp_ll_q;
  logic [dtw_pkg::LO_W+dtw_pkg::HI_W-1:0] pp_lh_q, pp_hl_q;
  logic [2*dtw_pkg::HI_W-1:0]            pp_hh_q;
  logic [dtw_pkg::PROD_W-1:0]            p_q, p_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= a_i[dtw_pkg::LO_W-1:0] * b_i[dtw_pkg::LO_W-1:0];
      pp_lh_q <= a_i[dtw_pkg::LO_W-1:0] * b_i[dtw_pkg::TS_W-1:dtw_pkg::LO_W];
      pp_hl_q <= a_i[dtw_pkg::TS_W-1:dtw_pkg::LO_W] * b_i[dtw_pkg::LO_W-1:0];
      pp_hh_q <= a_i[dtw_pkg::TS_W-1:dtw_pkg::LO_W] * b_i[dtw_pkg::TS_W-1:dtw_pkg::LO_W];
      p_q     <= p_d;
    end
  end

  always_comb begin
    p_d = dtw_pkg::PROD_W'(pp_ll_q)
        + ((dtw_pkg::PROD_W'(pp_lh_q) + dtw_pkg::PROD_W'(pp_hl_q)) << dtw_pkg::LO_W)
        + (dtw_pkg::PROD_W'(pp_hh_q) << (2 * dtw_pkg::LO_W));
  end

  assign p_o = p_q;

endmodule

### hdl/dtw_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_div_cell
// One restoring division step: shifts in one dividend bit, subtracts the
// divisor when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module dtw_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  dtw_pkg::cell_t cell_i,
  output dtw_pkg::cell_t cell_o
);

  dtw_pkg::cell_t          cell_q, cell_d;
  logic                    vld_q;
  logic [dtw_pkg::SUM_W:0] trial;
  logic                    fits;

  always_comb begin
    trial  = {cell_i.rem, cell_i.dvd[dtw_pkg::TS_W-1]};
    fits   = trial >= {1'b0, cell_i.den};
    cell_d = cell_i;
    cell_d.rem = fits ? dtw_pkg::SUM_W'(trial - {1'b0, cell_i.den})
                      : dtw_pkg::SUM_W'(trial);
    cell_d.dvd = cell_i.dvd << 1;
    cell_d.quo = {cell_i.quo[dtw_pkg::TS_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  // valid bit comes from the reset register, the rest from the data register
  always_comb begin
    cell_o     = cell_q;
    cell_o.vld = vld_q;
  end

endmodule

### hdl/dtw_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_scale
// Scales the time of flight to centimetres with saturation, gives zero for a
// negative time of flight and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module dtw_scale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  dtw_pkg::cell_t           cell_i,
  output logic                     vld_o,
  output logic [15:0]              distance_cm_o,
  output logic                     valid_res_o,
  output logic                     saturated_o
);

  logic [dtw_pkg::EXT_W-1:0]   tof_ext;
  logic [dtw_pkg::CAP_W-1:0]   tof_cap;
  logic                        va_q, vb_q, vo_q;
  logic                        sat_a_q, neg_a_q, sat_b_q, neg_b_q;
  logic [dtw_pkg::SP_W-1:0]    sp_q;
  logic [dtw_pkg::RP_W-1:0]    rp_q;
  logic [15:0]                 cm_q, cm_d;
  logic                        res_q, sat_q;

  always_comb begin
    tof_ext = dtw_pkg::EXT_W'(cell_i.quo);
    // an all-zero interval set divides by zero: quotient taken as zero
    tof_cap = cell_i.zero ? '0 : tof_ext[dtw_pkg::CAP_W-1:0];
    if (neg_b_q) begin
      cm_d = '0;
    end else if (sat_b_q) begin
      cm_d = 16'hffff;
    end else begin
      cm_d = rp_q[dtw_pkg::RECIP_SHIFT+15:dtw_pkg::RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= cell_i.vld;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_a_q <= !cell_i.neg && !cell_i.zero && (tof_ext >= dtw_pkg::SAT_TOF);
      neg_a_q <= cell_i.neg;
      sp_q    <= tof_cap * dtw_pkg::SCALE_NUM;
      sat_b_q <= sat_a_q;
      neg_b_q <= neg_a_q;
      rp_q    <= sp_q[dtw_pkg::X_W+dtw_pkg::DEN_SHIFT-1:dtw_pkg::DEN_SHIFT]
                 * dtw_pkg::RECIP_MUL;
      cm_q    <= cm_d;
      res_q   <= !neg_b_q;
      sat_q   <= sat_b_q;
    end
  end

  assign vld_o         = vo_q;
  assign distance_cm_o = cm_q;
  assign valid_res_o   = res_q;
  assign saturated_o   = sat_q;

endmodule

### hdl/ds_twr_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds_twr_distance
// Double-sided two-way ranging distance: intervals, round and reply products,
// a chain of restoring divider cells and centimetre scaling.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle unless stalled; a divider cell per quotient bit
// the whole pipeline holds while a result beat waits under out_stall_i
// reset clears the valid bits of every stage; data registers are not reset
module ds_twr_distance (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [dtw_pkg::IN_W-1:0] poll_tx_time_i,
  input  logic [dtw_pkg::IN_W-1:0] poll_rx_time_i,
  input  logic [dtw_pkg::IN_W-1:0] resp_tx_time_i,
  input  logic [dtw_pkg::IN_W-1:0] resp_rx_time_i,
  input  logic [dtw_pkg::IN_W-1:0] final_tx_time_i,
  input  logic [dtw_pkg::IN_W-1:0] final_rx_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [15:0]              distance_cm_o,
  output logic                     valid_res_o,
  output logic                     saturated_o
);

  logic                        adv;
  logic                        v0_q, v1_q, v2_q, v3_q;
  logic [dtw_pkg::TS_W-1:0]    round1_q, round2_q, reply1_q, reply2_q;
  logic [dtw_pkg::SUM_W-1:0]   sum_q, sum1_q, sum2_q;
  logic [dtw_pkg::PROD_W-1:0]  p_rnd, p_rep, diff;
  logic [dtw_pkg::PROD_W-1:0]  diff_q;
  logic                        neg_q;
  dtw_pkg::cell_t              head;
  dtw_pkg::cell_t              chain [0:dtw_pkg::TS_W];

  // pipeline moves unless a result beat is held at the output
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      round1_q <= dtw_pkg::TS_W'(resp_rx_time_i) - dtw_pkg::TS_W'(poll_tx_time_i);
      round2_q <= dtw_pkg::TS_W'(final_rx_time_i) - dtw_pkg::TS_W'(resp_tx_time_i);
      reply2_q <= dtw_pkg::TS_W'(final_tx_time_i) - dtw_pkg::TS_W'(resp_rx_time_i);
      reply1_q <= dtw_pkg::TS_W'(resp_tx_time_i) - dtw_pkg::TS_W'(poll_rx_time_i);
      sum_q    <= dtw_pkg::SUM_W'(round1_q) + dtw_pkg::SUM_W'(round2_q)
                + dtw_pkg::SUM_W'(reply1_q) + dtw_pkg::SUM_W'(reply2_q);
      sum1_q   <= sum_q;
      sum2_q   <= sum1_q;
      neg_q    <= p_rnd < p_rep;
      diff_q   <= diff;
    end
  end

  assign diff = p_rnd - p_rep;

  dtw_wide_mul u_mul_rnd (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (round1_q),
    .b_i   (round2_q),
    .p_o   (p_rnd)
  );

  dtw_wide_mul u_mul_rep (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (reply1_q),
    .b_i   (reply2_q),
    .p_o   (p_rep)
  );

  // the quotient fits TS_W bits, so the upper half starts below the divisor
  always_comb begin
    head.vld  = v3_q;
    head.rem  = dtw_pkg::SUM_W'(diff_q[dtw_pkg::PROD_W-1:dtw_pkg::TS_W]);
    head.dvd  = diff_q[dtw_pkg::TS_W-1:0];
    head.quo  = '0;
    head.den  = sum2_q;
    head.neg  = neg_q;
    head.zero = sum2_q == '0;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < dtw_pkg::TS_W; i++) begin : g_cell
    dtw_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  dtw_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .cell_i        (chain[dtw_pkg::TS_W]),
    .vld_o         (out_valid_o),
    .distance_cm_o (distance_cm_o),
    .valid_res_o   (valid_res_o),
    .saturated_o   (saturated_o)
  );

  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> distance_cm_o == 16'd0 && !saturated_o)
    else $error("invalid result with nonzero distance");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> distance_cm_o == 16'hffff && valid_res_o)
    else $error("saturated result not clamped");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output beat held");

endmodule
